/* src/wgc_pkg.sv */
// ----------------------------------------------------------------------------
// wgc_pkg
// Types, register indexes and helpers shared by the wrench gravity
// compensation block and its channel interfaces.
// ----------------------------------------------------------------------------
package wgc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int LEVER_W     = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_OFFSET_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_OFFSET_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_OFFSET_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_OFFSET_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_OFFSET_Z = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_WEIGHT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVER_ARM       = 3'd7;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic signed [15:0] rot_row_x;
        logic signed [15:0] rot_row_y;
        logic signed [15:0] rot_row_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] comp_force_x;
        logic signed [31:0] comp_force_y;
        logic signed [31:0] comp_force_z;
        logic signed [31:0] comp_torque_x;
        logic signed [31:0] comp_torque_y;
        logic signed [31:0] comp_torque_z;
    } result_t;

    // Clamp a 37-bit value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
        logic signed [31:0] r;
        if (x > 37'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -37'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* src/wgc_channels.sv */
// ----------------------------------------------------------------------------
// wgc channels
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface wgc_sample_if;
    import wgc_pkg::*;
    logic    valid;
    logic    ready;
    sample_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wgc_result_if;
    import wgc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wgc_cfg_if;
    import wgc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/wrench_gravity_compensation.sv */
// ----------------------------------------------------------------------------
// wrench_gravity_compensation
// Removes payload gravity and fixed offsets from a measured force/torque
// sample, given the third row of the sensor rotation matrix.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                              handshake
//   sample    sink       force, torque, rotation row          valid/ready
//   result    source     compensated force and torque         valid/ready
//   cfg       sink       register index, write data (63 b)    valid/ready
//
// Five register stages: weight*row multiply, gravity rounding, lever-arm
// products, torque sum, rounding/saturation into the output register.
// One transaction per cycle sustained while result.ready stays high.
// Each stage has its own valid bit and moves when the stage ahead is empty or
// moving, so bubbles close up while a result waits at the output.
// Reset clears the configuration registers and the stage valid bits, which
// empties the pipeline; cfg is always ready and must be written only while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module wrench_gravity_compensation (
    input  logic             clk,
    input  logic             rst_n,
    wgc_sample_if.sink       sample,
    wgc_result_if.source     result,
    wgc_cfg_if.sink          cfg
);
    import wgc_pkg::*;

    // configuration
    logic signed [31:0]         force_offset_reg [3];
    logic signed [31:0]         torque_offset_reg [3];
    logic signed [31:0]         weight_reg;
    logic [CFG_DATA_W-1:0]      lever_reg;
    logic signed [LEVER_W-1:0]  lever [3];

    // stage valids and enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, s5_valid_next;
    logic en1, en2, en3, en4, en5;

    // stage payloads
    logic signed [31:0] in_force [3];
    logic signed [31:0] in_torque [3];
    logic signed [15:0] in_rot [3];

    logic signed [47:0] s1_prod_reg [3];
    logic signed [31:0] s1_force_reg [3];
    logic signed [31:0] s1_torque_reg [3];

    logic signed [47:0] s2_round [3];
    logic signed [33:0] s2_grav_next [3];
    logic signed [33:0] s2_grav_reg [3];
    logic signed [31:0] s2_force_reg [3];
    logic signed [31:0] s2_torque_reg [3];

    logic signed [54:0] s3_pa_reg [3];
    logic signed [54:0] s3_pb_reg [3];
    logic signed [34:0] s3_fsum_reg [3];
    logic signed [32:0] s3_tdiff_reg [3];

    logic signed [56:0] s4_acc_next [3];
    logic signed [56:0] s4_acc_reg [3];
    logic signed [34:0] s4_fsum_reg [3];

    logic signed [56:0] s5_round [3];
    logic signed [31:0] s5_torque [3];
    logic signed [31:0] s5_force [3];
    result_t            out_reg;
    result_t            out_next;

    // ---------------- configuration port ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                force_offset_reg[i]  <= '0;
                torque_offset_reg[i] <= '0;
            end
            weight_reg <= '0;
            lever_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FORCE_OFFSET_X:  force_offset_reg[0]  <= cfg.data[31:0];
                REG_FORCE_OFFSET_Y:  force_offset_reg[1]  <= cfg.data[31:0];
                REG_FORCE_OFFSET_Z:  force_offset_reg[2]  <= cfg.data[31:0];
                REG_TORQUE_OFFSET_X: torque_offset_reg[0] <= cfg.data[31:0];
                REG_TORQUE_OFFSET_Y: torque_offset_reg[1] <= cfg.data[31:0];
                REG_TORQUE_OFFSET_Z: torque_offset_reg[2] <= cfg.data[31:0];
                REG_PAYLOAD_WEIGHT:  weight_reg           <= cfg.data[31:0];
                REG_LEVER_ARM:       lever_reg            <= cfg.data;
                default:             ;
            endcase
        end
    end

    assign lever[0] = lever_reg[LEVER_W-1:0];
    assign lever[1] = lever_reg[2*LEVER_W-1:LEVER_W];
    assign lever[2] = lever_reg[3*LEVER_W-1:2*LEVER_W];

    // ---------------- flow control ----------------
    assign en5 = !s5_valid_reg || result.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign sample.ready = en1;

    assign s1_valid_next = en1 ? sample.valid : s1_valid_reg;
    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = en4 ? s3_valid_reg : s4_valid_reg;
    assign s5_valid_next = en5 ? s4_valid_reg : s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    // ---------------- stage 1: weight times rotation row ----------------
    assign in_force[0]  = sample.data.force_x;
    assign in_force[1]  = sample.data.force_y;
    assign in_force[2]  = sample.data.force_z;
    assign in_torque[0] = sample.data.torque_x;
    assign in_torque[1] = sample.data.torque_y;
    assign in_torque[2] = sample.data.torque_z;
    assign in_rot[0]    = sample.data.rot_row_x;
    assign in_rot[1]    = sample.data.rot_row_y;
    assign in_rot[2]    = sample.data.rot_row_z;

    always_ff @(posedge clk)
    begin
        if (en1 && sample.valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_prod_reg[i]   <= 48'(weight_reg) * 48'(in_rot[i]);
                s1_force_reg[i]  <= in_force[i];
                s1_torque_reg[i] <= in_torque[i];
            end
        end
    end

    // ---------------- stage 2: round gravity to Q16.16 ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_round[i]     = s1_prod_reg[i] + 48'sd8192;
            s2_grav_next[i] = s2_round[i][47:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_grav_reg[i]   <= s2_grav_next[i];
                s2_force_reg[i]  <= s1_force_reg[i];
                s2_torque_reg[i] <= s1_torque_reg[i];
            end
        end
    end

    // ---------------- stage 3: lever-arm products, force sum ----------------
    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_pa_reg[0] <= 55'(s2_grav_reg[2]) * 55'(lever[1]);
            s3_pb_reg[0] <= 55'(s2_grav_reg[1]) * 55'(lever[2]);
            s3_pa_reg[1] <= 55'(s2_grav_reg[0]) * 55'(lever[2]);
            s3_pb_reg[1] <= 55'(s2_grav_reg[2]) * 55'(lever[0]);
            s3_pa_reg[2] <= 55'(s2_grav_reg[1]) * 55'(lever[0]);
            s3_pb_reg[2] <= 55'(s2_grav_reg[0]) * 55'(lever[1]);
            for (int i = 0; i < 3; i++)
            begin
                s3_fsum_reg[i]  <= 35'(s2_force_reg[i]) + 35'(s2_grav_reg[i])
                                   - 35'(force_offset_reg[i]);
                s3_tdiff_reg[i] <= 33'(s2_torque_reg[i]) - 33'(torque_offset_reg[i]);
            end
        end
    end

    // ---------------- stage 4: torque accumulation in 2^-36 units ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_acc_next[i] = 57'($signed({s3_tdiff_reg[i], 20'b0}))
                             + 57'(s3_pa_reg[i]) - 57'(s3_pb_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_acc_reg[i]  <= s4_acc_next[i];
                s4_fsum_reg[i] <= s3_fsum_reg[i];
            end
        end
    end

    // ---------------- stage 5: round, saturate, output register ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_round[i]  = s4_acc_reg[i] + 57'sd524288;
            s5_torque[i] = sat32(s5_round[i][56:20]);
            s5_force[i]  = sat32(37'(s4_fsum_reg[i]));
        end
        out_next.comp_force_x  = s5_force[0];
        out_next.comp_force_y  = s5_force[1];
        out_next.comp_force_z  = s5_force[2];
        out_next.comp_torque_x = s5_torque[0];
        out_next.comp_torque_y = s5_torque[1];
        out_next.comp_torque_z = s5_torque[2];
    end

    always_ff @(posedge clk)
    begin
        if (en5 && s4_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = s5_valid_reg;
    assign result.data  = out_reg;

    // ---------------- assertions ----------------
    a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(sample.valid))
        else $error("stage 1 filled without an accepted sample");

    a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s5_valid_reg) |-> $past(s4_valid_reg))
        else $error("result appeared without a stage 4 entry");

    a_stall_holds_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !en3) |=> s3_valid_reg)
        else $error("stalled stage 3 entry was lost");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                           && s4_valid_reg && s5_valid_reg))
        else $error("sample blocked while the pipeline has a free stage");

endmodule
